@@ rtl/encoder_move_pwm_sequencer_unit_macros.svh @@
// Assertion macros shared by the checker files of the move sequencer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ENCODER_MOVE_PWM_SEQUENCER_UNIT_MACROS_SVH
`define ENCODER_MOVE_PWM_SEQUENCER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EMPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define EMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/emps_pkg.sv @@
// Shared constants, register indexes and divider request types of the move sequencer.
// No dependencies.
package emps_pkg;

  localparam int unsigned SYS_CLOCK_HZ_DEF = 125000000;

  localparam int unsigned DIV_W      = 32;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned WRAP_W     = 16;
  localparam int unsigned D16_W      = 12;
  localparam int unsigned WD_W       = 23;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned TDATA_W    = 72;
  localparam int unsigned PCT_DIV    = 100;

  localparam logic [CFG_ADDR_W-1:0] REG_FREQ       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_DUTY = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_DUTY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOW_THR   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_THR   = 3'd4;

  localparam logic [FREQ_W-1:0] FREQ_RST       = 20'd1000;
  localparam logic [DUTY_W-1:0] START_DUTY_RST = 7'd70;
  localparam logic [DUTY_W-1:0] SLOW_DUTY_RST  = 7'd20;
  localparam logic [CNT_W-1:0]  SLOW_THR_RST   = 16'd900;
  localparam logic [CNT_W-1:0]  STOP_THR_RST   = 16'd990;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
  localparam logic [D16_W-1:0]  D16_MIN  = 12'd16;
  localparam logic [D16_W-1:0]  D16_MAX  = 12'd4095;
  localparam logic [WRAP_W-1:0] WRAP_MAX = 16'hFFFF;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/emps_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on emps_pkg for the request and response types.
module emps_div import emps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]  num_q, rem_q, den_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DIV_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[DIV_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= req_i.steps;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - STEP_W'(1);
      done_q <= (cnt_q == STEP_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/encoder_move_pwm_sequencer_unit.sv @@
// Top level of the encoder move sequencer with PWM divider, wrap and compare output.
// Depends on emps_pkg and the serial divider emps_div.
//
// Each request on the slave stream is one encoder pulse count. Each produces exactly
// one request on the master stream carrying the driver enable, applied duty, PWM
// divider, wrap, compare level and running total; tlast marks the request that
// finishes a move. Registers are to be written through the plain write port only
// while idle; the block itself does not enforce this. Divider and wrap depend only on
// the frequency and are kept until it is written. With them kept, a request runs the
// serial divide by 100 of 23 steps for the compare level. After reset or a frequency
// write the first request also runs the divider ceiling and the wrap divide first.
// One divider is shared and works one quotient bit per cycle, so one request is in
// work at a time. A new request is taken while the previous result still waits on
// the master side; a finished result waits inside the block until the output
// register is free. Reset restores all register defaults, an empty total and the
// start duty.

module encoder_move_pwm_sequencer_unit import emps_pkg::*; #(
  parameter int unsigned SYS_CLOCK_HZ = SYS_CLOCK_HZ_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // pulses[15:0]
  input  logic [CNT_W-1:0]      s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // motor_enable[0], duty_percent[7:1], divider_int[15:8], divider_frac[19:16],
  // pwm_wrap[35:20], compare_level[51:36], total_count[67:52], zero[71:68]
  output logic [TDATA_W-1:0]    m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CLK_W   = $clog2(SYS_CLOCK_HZ + 1);
  localparam int unsigned QA_W    = CLK_W - 12;
  localparam int unsigned D16F_W  = (QA_W + 1 > D16_W + 1) ? QA_W + 1 : D16_W + 1;
  localparam logic [STEP_W-1:0] STEPS_A = STEP_W'(QA_W);
  localparam logic [STEP_W-1:0] STEPS_B = STEP_W'(CLK_W + 4);
  localparam logic [STEP_W-1:0] STEPS_C = STEP_W'(WD_W);
  localparam logic [DIV_W-1:0]  NUM_A   = DIV_W'(SYS_CLOCK_HZ / 4096) << (DIV_W - QA_W);
  localparam logic [DIV_W-1:0]  NUM_B   = DIV_W'(SYS_CLOCK_HZ) << (DIV_W - CLK_W);
  localparam logic [DIV_W-1:0]  DEN_C   = DIV_W'(PCT_DIV);
  localparam logic              CLK_LOW_NZ = (SYS_CLOCK_HZ % 4096) != 0;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV_A  = 7'b0000010,
    ST_LOAD_B = 7'b0000100,
    ST_DIV_B  = 7'b0001000,
    ST_LOAD_C = 7'b0010000,
    ST_DIV_C  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [FREQ_W-1:0] freq_q;
  logic [DUTY_W-1:0] start_duty_q, slow_duty_q;
  logic [CNT_W-1:0]  slow_thr_q, stop_thr_q;
  logic              pwm_ok_q;

  logic              finishing_q;
  logic [CNT_W-1:0]  total_q;
  logic [DUTY_W-1:0] act_q;

  logic [DUTY_W-1:0] it_duty_q;
  logic              it_done_q;
  logic [CNT_W-1:0]  it_total_q;
  logic [D16_W-1:0]  d16_q;
  logic [WRAP_W-1:0] wrap_q, cmp_q;

  logic               m_valid_q, m_last_q;
  logic [TDATA_W-1:0] m_data_q;

  logic              accept, out_free, fin_now;
  logic [CNT_W-1:0]  sum;
  logic [DUTY_W-1:0] act_use, duty_clamp;
  logic [FREQ_W-1:0] freq_eff;
  logic [DIV_W-1:0]  prod;
  logic [WD_W-1:0]   wd;
  logic [QA_W-1:0]   qa;
  logic [D16F_W-1:0] d16_full;
  logic [D16_W-1:0]  d16_next;
  logic [CLK_W-1:0]  qb, qb_m1;
  logic [WRAP_W-1:0] wrap_next;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  emps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  always_comb begin
    fin_now    = finishing_q | (total_q >= stop_thr_q);
    sum        = total_q + s_axis_tdata_i;
    act_use    = (!fin_now && (total_q > slow_thr_q)) ? slow_duty_q : act_q;
    duty_clamp = (act_use > DUTY_MAX) ? DUTY_MAX : act_use;
    freq_eff   = (freq_q == '0) ? FREQ_W'(1) : freq_q;
    prod       = DIV_W'(d16_q) * DIV_W'(freq_eff);
    wd         = WD_W'(wrap_q) * WD_W'(it_duty_q);
  end

  always_comb begin
    qa       = div_rsp.quo[QA_W-1:0];
    d16_full = D16F_W'(qa) + D16F_W'((div_rsp.rem != '0) | CLK_LOW_NZ);
    if (d16_full < D16F_W'(D16_MIN)) begin
      d16_next = D16_MIN;
    end else if (d16_full > D16F_W'(D16_MAX)) begin
      d16_next = D16_MAX;
    end else begin
      d16_next = d16_full[D16_W-1:0];
    end
    qb    = div_rsp.quo[CLK_W-1:0];
    qb_m1 = qb - CLK_W'(1);
    if (qb == '0) begin
      wrap_next = '0;
    end else if (qb_m1 > CLK_W'(WRAP_MAX)) begin
      wrap_next = WRAP_MAX;
    end else begin
      wrap_next = qb_m1[WRAP_W-1:0];
    end
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = NUM_A;
    div_req.den   = DIV_W'(freq_eff);
    div_req.steps = STEPS_A;
    if (accept && !pwm_ok_q) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_LOAD_B) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_B;
      div_req.den   = prod;
      div_req.steps = STEPS_B;
    end else if (state_q == ST_LOAD_C) begin
      div_req.start = 1'b1;
      div_req.num   = {wd, (DIV_W - WD_W)'(0)};
      div_req.den   = DEN_C;
      div_req.steps = STEPS_C;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = pwm_ok_q ? ST_LOAD_C : ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (div_rsp.done) begin
          state_d = ST_LOAD_B;
        end
      end
      ST_LOAD_B: state_d = ST_DIV_B;
      ST_DIV_B: begin
        if (div_rsp.done) begin
          state_d = ST_LOAD_C;
        end
      end
      ST_LOAD_C: state_d = ST_DIV_C;
      ST_DIV_C: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q       <= FREQ_RST;
      start_duty_q <= START_DUTY_RST;
      slow_duty_q  <= SLOW_DUTY_RST;
      slow_thr_q   <= SLOW_THR_RST;
      stop_thr_q   <= STOP_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FREQ:       freq_q       <= cfg_wdata_i;
        REG_START_DUTY: start_duty_q <= cfg_wdata_i[DUTY_W-1:0];
        REG_SLOW_DUTY:  slow_duty_q  <= cfg_wdata_i[DUTY_W-1:0];
        REG_SLOW_THR:   slow_thr_q   <= cfg_wdata_i[CNT_W-1:0];
        REG_STOP_THR:   stop_thr_q   <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_ok_q <= 1'b0;
    end else if (cfg_we_i && (cfg_addr_i == REG_FREQ)) begin
      pwm_ok_q <= 1'b0;
    end else if ((state_q == ST_DIV_B) && div_rsp.done) begin
      pwm_ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finishing_q <= 1'b0;
      total_q     <= '0;
      act_q       <= START_DUTY_RST;
    end else if (accept) begin
      if (fin_now) begin
        finishing_q <= 1'b0;
        total_q     <= '0;
        act_q       <= start_duty_q;
      end else begin
        finishing_q <= (sum >= stop_thr_q);
        total_q     <= sum;
        act_q       <= act_use;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_duty_q  <= duty_clamp;
      it_done_q  <= fin_now;
      it_total_q <= sum;
    end
    if ((state_q == ST_DIV_A) && div_rsp.done) begin
      d16_q <= d16_next;
    end
    if ((state_q == ST_DIV_B) && div_rsp.done) begin
      wrap_q <= wrap_next;
    end
    if ((state_q == ST_DIV_C) && div_rsp.done) begin
      cmp_q <= div_rsp.quo[WRAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      m_data_q <= {4'b0000, it_total_q, cmp_q, wrap_q, d16_q[3:0], d16_q[D16_W-1:4],
                   it_duty_q, ~it_done_q};
      m_last_q <= it_done_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

@@ rtl/emps_chk.sv @@
// Port-level checker for the move sequencer and its bind to the top level.
// Depends on the assertion macros header.
`include "encoder_move_pwm_sequencer_unit_macros.svh"

module emps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  `EMPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "Stalled result changed.")
  `EMPS_ASSERT_NEXT(a_one_in_work, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "Second request taken while one is in work.")
  `EMPS_ASSERT_NOW(a_enable_vs_done, m_axis_tvalid_o, m_axis_tdata_o[0] != m_axis_tlast_o, "Enable and move end disagree.")
  `EMPS_ASSERT_NOW(a_duty_range, m_axis_tvalid_o, m_axis_tdata_o[7:1] <= 7'd100, "Duty above full scale.")
  `EMPS_ASSERT_NOW(a_cmp_le_wrap, m_axis_tvalid_o, m_axis_tdata_o[51:36] <= m_axis_tdata_o[35:20], "Compare level above wrap.")

endmodule

bind encoder_move_pwm_sequencer_unit emps_chk u_emps_chk (.*);
